### sv/clsp_pkg.sv
package clsp_pkg;

    // Default width of the saturating magnitude accumulator.
    localparam int MAG_BITS = 24;

    // Width of the signed literal on the result channel.
    localparam int VALUE_W = 25;

    // Default depth of the event queue between parser and output stage.
    localparam int QUEUE_DEPTH = 4;

    // Byte codes that the parser recognises.
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds.
    localparam logic KIND_LITERAL    = 1'b0;
    localparam logic KIND_CLAUSE_END = 1'b1;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_GAP     = 2'd2,
        MODE_TOKEN   = 2'd3
    } parse_mode_t;

    // One queue entry: everything a single input byte produced.
    typedef struct packed {
        logic               has_lit;
        logic               has_end;
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic               done;
    } clsp_event_t;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic nonempty;
    } clsp_qstat_t;

endpackage

### sv/clsp_in_if.sv
interface clsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_stream;

    modport source (output valid, output char_code, output end_of_stream, input ready);
    modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

### sv/clsp_out_if.sv
interface clsp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               out_kind;
    logic signed [clsp_pkg::VALUE_W-1:0] literal_value;
    logic                               magnitude_overflow;
    logic                               run_last;
    logic                               stream_done;

    modport source (output valid, output out_kind, output literal_value,
                    output magnitude_overflow, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input out_kind, input literal_value,
                    input magnitude_overflow, input run_last, input stream_done,
                    output ready);
endinterface

### sv/clsp_front.sv
module clsp_front #(
    parameter int MAG_BITS = clsp_pkg::MAG_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    clsp_in_if.sink               text,
    input  clsp_pkg::clsp_qstat_t stat,
    output logic                  push,
    output clsp_pkg::clsp_event_t ev
);

    localparam int EXT_W = MAG_BITS + clsp_pkg::VALUE_W;
    localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

    clsp_pkg::parse_mode_t mode_reg, mode_next;
    logic                  neg_reg, neg_next;
    logic [MAG_BITS-1:0]   mag_reg, mag_next;
    logic                  sat_reg, sat_next;
    logic                  nonempty_reg, nonempty_next;

    logic                          accept;
    logic                          gap;
    logic                          run_token;
    logic                          t_neg;
    logic [MAG_BITS-1:0]           t_mag;
    logic                          t_sat;
    logic [3:0]                    digit;
    logic [MAG_BITS+3:0]           prod;
    logic                          lit_neg;
    logic [MAG_BITS-1:0]           lit_mag;
    logic [EXT_W-1:0]              lit_ext;
    logic [clsp_pkg::VALUE_W-1:0]  lit_low;

    assign text.ready = !stat.full;
    assign accept     = text.valid && text.ready;
    assign digit      = 4'(text.char_code - clsp_pkg::CH_ZERO);
    assign prod       = {1'b0, t_mag, 3'b000} + {3'b000, t_mag, 1'b0}
                      + {{MAG_BITS{1'b0}}, digit};

    // Only the low bits of the magnitude reach the literal.
    assign lit_ext = {{clsp_pkg::VALUE_W{1'b0}}, lit_mag};
    assign lit_low = lit_ext[clsp_pkg::VALUE_W-1:0];

    always_comb
    begin
        mode_next     = mode_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        sat_next      = sat_reg;
        nonempty_next = nonempty_reg;
        gap           = 1'b0;
        run_token     = 1'b0;
        t_neg         = neg_reg;
        t_mag         = mag_reg;
        t_sat         = sat_reg;
        lit_neg       = neg_reg;
        lit_mag       = mag_reg;
        ev.has_lit    = 1'b0;
        ev.has_end    = 1'b0;
        ev.ovf        = 1'b0;
        ev.done       = text.end_of_stream;

        case (mode_reg)
            clsp_pkg::MODE_START:
            begin
                if (text.char_code == clsp_pkg::CH_C || text.char_code == clsp_pkg::CH_P)
                    mode_next = clsp_pkg::MODE_COMMENT;
                else
                    gap = 1'b1;
            end
            clsp_pkg::MODE_COMMENT:
            begin
                if (text.char_code == clsp_pkg::CH_NL)
                    mode_next = clsp_pkg::MODE_START;
            end
            clsp_pkg::MODE_GAP:
                gap = 1'b1;
            clsp_pkg::MODE_TOKEN:
                run_token = 1'b1;
            default:
                mode_next = clsp_pkg::MODE_START;
        endcase

        if (gap)
        begin
            if (text.char_code inside {[clsp_pkg::CH_TAB:clsp_pkg::CH_CR], clsp_pkg::CH_SPACE})
            begin
                // Whitespace between tokens is dropped.
            end
            else if (text.char_code == clsp_pkg::CH_MINUS)
            begin
                mode_next = clsp_pkg::MODE_TOKEN;
                neg_next  = 1'b1;
                mag_next  = '0;
                sat_next  = 1'b0;
            end
            else
            begin
                run_token = 1'b1;
                t_neg     = 1'b0;
                t_mag     = '0;
                t_sat     = 1'b0;
            end
        end

        if (run_token)
        begin
            if (text.char_code inside {[clsp_pkg::CH_ZERO:clsp_pkg::CH_NINE]})
            begin
                mode_next = clsp_pkg::MODE_TOKEN;
                neg_next  = t_neg;
                if (prod[MAG_BITS+3:MAG_BITS] != 4'd0)
                begin
                    mag_next = MAG_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    mag_next = prod[MAG_BITS-1:0];
                    sat_next = t_sat;
                end
            end
            else if (t_mag != '0)
            begin
                ev.has_lit    = 1'b1;
                ev.ovf        = t_sat;
                lit_neg       = t_neg;
                lit_mag       = t_mag;
                nonempty_next = 1'b1;
                mode_next     = clsp_pkg::MODE_GAP;
                neg_next      = t_neg;
                mag_next      = t_mag;
                sat_next      = t_sat;
            end
            else
            begin
                ev.has_end    = nonempty_reg;
                mode_next     = clsp_pkg::MODE_START;
                neg_next      = 1'b0;
                mag_next      = '0;
                sat_next      = 1'b0;
                nonempty_next = 1'b0;
            end
        end

        if (text.end_of_stream)
        begin
            // Flush a pending token and close an open clause.
            if (mode_next == clsp_pkg::MODE_TOKEN && mag_next != '0)
            begin
                ev.has_lit    = 1'b1;
                ev.ovf        = sat_next;
                lit_neg       = neg_next;
                lit_mag       = mag_next;
                nonempty_next = 1'b1;
            end
            if ((mode_next == clsp_pkg::MODE_TOKEN || mode_next == clsp_pkg::MODE_GAP)
                && nonempty_next)
                ev.has_end = 1'b1;
            mode_next     = clsp_pkg::MODE_START;
            neg_next      = 1'b0;
            mag_next      = '0;
            sat_next      = 1'b0;
            nonempty_next = 1'b0;
        end

        ev.value = lit_neg ? (~lit_low + 1'b1) : lit_low;
        push     = accept && (ev.has_lit || ev.has_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= clsp_pkg::MODE_START;
            neg_reg      <= 1'b0;
            mag_reg      <= '0;
            sat_reg      <= 1'b0;
            nonempty_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            neg_reg      <= neg_next;
            mag_reg      <= mag_next;
            sat_reg      <= sat_next;
            nonempty_reg <= nonempty_next;
        end
    end

    // A byte can only yield both a literal and a clause end when it closes the stream.
    a_pair_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && ev.has_lit && ev.has_end |-> ev.done)
        else $error("literal and clause end from one byte without end of stream");

    // After the last byte of a stream the parser is back at a clause start.
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_stream |=> mode_reg == clsp_pkg::MODE_START && !nonempty_reg)
        else $error("parser state not cleared after end of stream");

endmodule

### sv/clsp_queue.sv
module clsp_queue #(
    parameter int DEPTH = clsp_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  clsp_pkg::clsp_event_t wr_data,
    input  logic                  pop,
    output clsp_pkg::clsp_event_t head,
    output clsp_pkg::clsp_qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    clsp_pkg::clsp_event_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head          = mem_reg[rd_ptr_reg];
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.nonempty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Neither overflow nor underflow reaches the counters.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && stat.full |-> pop) and (pop |-> stat.nonempty))
        else $error("event queue pushed when full or popped when empty");

endmodule

### sv/clsp_back.sv
module clsp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clsp_pkg::clsp_event_t head,
    input  clsp_pkg::clsp_qstat_t stat,
    output logic                  pop,
    clsp_out_if.source            result
);

    logic                          ov_reg, ov_next;
    logic                          phase_reg, phase_next;
    logic                          kind_reg;
    logic [clsp_pkg::VALUE_W-1:0]  value_reg;
    logic                          ovf_reg;
    logic                          last_reg;
    logic                          done_reg;

    logic ld;
    logic first_lit;
    logic item_last;

    always_comb
    begin
        ld         = stat.nonempty && (!ov_reg || result.ready);
        first_lit  = head.has_lit && !phase_reg;
        item_last  = first_lit ? !head.has_end : 1'b1;
        pop        = ld && item_last;
        phase_next = ld ? !item_last : phase_reg;
        if (ld)
            ov_next = 1'b1;
        else if (result.ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            ov_reg    <= ov_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            kind_reg  <= first_lit ? clsp_pkg::KIND_LITERAL : clsp_pkg::KIND_CLAUSE_END;
            value_reg <= first_lit ? head.value : '0;
            ovf_reg   <= first_lit ? head.ovf : 1'b0;
            last_reg  <= item_last;
            done_reg  <= item_last && head.done;
        end
    end

    assign result.valid              = ov_reg;
    assign result.out_kind           = kind_reg;
    assign result.literal_value      = value_reg;
    assign result.magnitude_overflow = ovf_reg;
    assign result.run_last           = last_reg;
    assign result.stream_done        = done_reg;

    // Mid-way through a two-result entry, that entry is still at the head.
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> stat.nonempty && head.has_lit && head.has_end)
        else $error("second half of an entry without a matching head");

    // The end of a stream is always the last result of its byte.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.stream_done |-> result.run_last)
        else $error("stream_done on a result that is not the last of its byte");

endmodule

### sv/cnf_literal_stream_parser_unit.sv
// Path: a result reaches the result channel through the event queue and then the output register.
// Throughput: one byte per cycle while the event queue has room; a byte that gives a literal
// and a clause end loads the output register twice, and the event queue absorbs such bursts.
// Reset (rst_n low, asynchronous): the parser returns to a clause start with an empty
// accumulator, the event queue empties and the result channel drops valid.
module cnf_literal_stream_parser_unit #(
    parameter int MAG_BITS    = clsp_pkg::MAG_BITS,
    parameter int QUEUE_DEPTH = clsp_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    clsp_in_if.sink    text,
    clsp_out_if.source result
);

    // The front end parses one text item per cycle while the queue has room. It keeps the
    // parse mode, the sign, the saturating magnitude and whether the current clause holds
    // a literal. Every byte that produces output leaves exactly one entry in the queue,
    // carrying a literal, a clause end, or both when the byte also closes the stream.
    clsp_pkg::clsp_event_t ev;
    clsp_pkg::clsp_event_t head;
    clsp_pkg::clsp_qstat_t stat;
    logic                  push;
    logic                  pop;

    clsp_front #(
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .stat  (stat),
        .push  (push),
        .ev    (ev)
    );

    // The queue decouples the parser from a stalling consumer. The parser stops
    // taking bytes only when the queue is full.
    clsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (ev),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    // The back end splits each entry into one or two result items, marks the last
    // result of each byte and the final result of the stream, and holds each item in
    // an output register until it is taken.
    clsp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (stat),
        .pop    (pop),
        .result (result)
    );

endmodule

### tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Width of the magnitude accumulator and its saturation ceiling, as the block is built.
    localparam int MAG_W = clsp_pkg::MAG_BITS;
    localparam longint unsigned MAG_MAX = (64'd1 << MAG_W) - 1;

    // Width of the signed literal on the result channel.
    localparam int VALUE_W = clsp_pkg::VALUE_W;

    // The two whitespace bytes that the package does not name.
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    // Least number of random text bytes queued in each idling phase.
    localparam int PHASE_BYTES = 450;

    // One byte of CNF text together with its end-of-stream mark.
    typedef struct {
        logic [7:0] code;
        logic       eos;
    } text_item_t;

    // One parsed token as the result channel should present it.
    typedef struct {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic               last;
        logic               done;
    } cnf_result_t;

    logic clk;
    logic rst_n;

    clsp_in_if  text_if ();
    clsp_out_if result_if ();

    cnf_literal_stream_parser_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if.sink),
        .result (result_if.source)
    );

    // Bytes waiting to be offered, and tokens that the parser should still produce.
    text_item_t  text_bytes[$];
    cnf_result_t parsed_tokens[$];

    // Results of the byte currently being parsed, gathered before they are released.
    cnf_result_t step_out[$];

    // Scratch text of the random stream under construction.
    logic [7:0] draft[$];

    int   queued;
    int   errors;
    int   send_idle_pct;
    int   stall_pct;
    logic text_taken;

    // Our own copy of the parser state.
    clsp_pkg::parse_mode_t mode;
    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic                  sat;
    logic                  clause_open;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    // Back to a clause start with nothing accumulated; used after reset, after a
    // clause has been closed by an empty token and after the end of a stream.
    task clear_parser();
        mode        = clsp_pkg::MODE_START;
        neg         = 1'b0;
        mag         = '0;
        sat         = 1'b0;
        clause_open = 1'b0;
    endtask

    // Adds one result to those of the byte being parsed.
    task note_result(input cnf_result_t r);
        step_out.insert(step_out.size(), r);
    endtask

    // The literal held in the accumulator, with its polarity applied and cut to the
    // width of the result field.
    function automatic cnf_result_t literal_now();
        cnf_result_t     r;
        longint unsigned acc;
        acc     = mag;
        r.kind  = clsp_pkg::KIND_LITERAL;
        r.value = VALUE_W'(neg ? 64'd0 - acc : acc);
        r.ovf   = sat;
        r.last  = 1'b0;
        r.done  = 1'b0;
        return r;
    endfunction

    function automatic cnf_result_t clause_end();
        cnf_result_t r;
        r.kind  = clsp_pkg::KIND_CLAUSE_END;
        r.value = '0;
        r.ovf   = 1'b0;
        r.last  = 1'b0;
        r.done  = 1'b0;
        return r;
    endfunction

    // A byte inside a token. A digit is folded into the magnitude, which sticks at
    // its ceiling once it would overflow. Anything else ends the token and is
    // swallowed: a nonzero magnitude becomes a literal, while an empty or zero
    // token closes the clause, which is only reported when it held a literal.
    task token_step(input logic [7:0] code);
        longint unsigned acc;
        longint unsigned digit;
        if (code >= clsp_pkg::CH_ZERO && code <= clsp_pkg::CH_NINE)
        begin
            acc   = mag;
            digit = code - clsp_pkg::CH_ZERO;
            if (acc > (MAG_MAX - digit) / 10)
            begin
                mag = MAG_W'(MAG_MAX);
                sat = 1'b1;
            end
            else
            begin
                mag = MAG_W'(acc * 10 + digit);
            end
        end
        else if (mag != 0)
        begin
            note_result(literal_now());
            clause_open = 1'b1;
            mode        = clsp_pkg::MODE_GAP;
        end
        else
        begin
            if (clause_open)
                note_result(clause_end());
            clear_parser();
        end
    endtask

    // A byte between tokens: whitespace is skipped, a minus opens a negative token,
    // and any other byte opens a positive token and is then treated as part of it.
    task gap_step(input logic [7:0] code);
        if (code == clsp_pkg::CH_SPACE || (code >= clsp_pkg::CH_TAB && code <= clsp_pkg::CH_CR))
            return;
        neg  = (code == clsp_pkg::CH_MINUS);
        mag  = '0;
        sat  = 1'b0;
        mode = clsp_pkg::MODE_TOKEN;
        if (code != clsp_pkg::CH_MINUS)
            token_step(code);
    endtask

    // Works out every result that one accepted byte causes and queues them in order.
    task parse_byte(input logic [7:0] code, input logic eos);
        step_out.delete();
        case (mode)
            clsp_pkg::MODE_START:
            begin
                // Comment and problem lines are only recognised at a clause start.
                if (code == clsp_pkg::CH_C || code == clsp_pkg::CH_P)
                    mode = clsp_pkg::MODE_COMMENT;
                else
                    gap_step(code);
            end
            clsp_pkg::MODE_COMMENT:
            begin
                if (code == clsp_pkg::CH_NL)
                    mode = clsp_pkg::MODE_START;
            end
            clsp_pkg::MODE_GAP:
            begin
                gap_step(code);
            end
            default:
            begin
                token_step(code);
            end
        endcase
        if (eos)
        begin
            // The stream ends here: flush a pending token and close an open clause.
            // An unterminated comment simply ends without any result.
            if (mode == clsp_pkg::MODE_TOKEN && mag != 0)
            begin
                note_result(literal_now());
                clause_open = 1'b1;
            end
            if ((mode == clsp_pkg::MODE_TOKEN || mode == clsp_pkg::MODE_GAP) && clause_open)
                note_result(clause_end());
            if (step_out.size() != 0)
                step_out[$].done = 1'b1;
            clear_parser();
        end
        if (step_out.size() != 0)
            step_out[$].last = 1'b1;
        foreach (step_out[i])
            parsed_tokens.insert(parsed_tokens.size(), step_out[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task add_byte(input logic [7:0] code, input logic eos);
        text_item_t it;
        it.code = code;
        it.eos  = eos;
        text_bytes.insert(text_bytes.size(), it);
        queued++;
    endtask

    // Queues a whole string, optionally marking its last byte as the end of the stream.
    task add_text(input string s, input logic eos_last);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], eos_last && i == s.len() - 1);
    endtask

    task add_draft_byte(input logic [7:0] b);
        draft.insert(draft.size(), b);
    endtask

    task draft_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_draft_byte(s[i]);
    endtask

    // Whitespace of every kind, with the plain space the most common.
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(9))
            0:       return clsp_pkg::CH_TAB;
            1:       return clsp_pkg::CH_NL;
            2:       return clsp_pkg::CH_CR;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return clsp_pkg::CH_SPACE;
        endcase
    endfunction

    // Builds one CNF text: an optional problem line, then a few clauses of signed
    // literals ended by zero, with comment lines at some clause starts. Most of
    // these go out whole with the end mark on their final byte; some are cut off
    // at a random point, some carry no end mark and run on into the next text,
    // and in some, random bytes take the place of some of the text.
    task add_random_stream();
        int   n_clauses;
        int   n_lits;
        int   pick;
        int   shape;
        int   cut;
        bit   noisy;
        draft.delete();
        if ($urandom_range(1))
            draft_text($sformatf("p cnf %0d %0d\n", $urandom_range(1, 300),
                                 $urandom_range(1, 900)));
        n_clauses = $urandom_range(1, 5);
        repeat (n_clauses)
        begin
            if ($urandom_range(9) < 3)
            begin
                add_draft_byte(clsp_pkg::CH_C);
                repeat ($urandom_range(0, 6))
                    add_draft_byte(8'($urandom_range(32, 126)));
                add_draft_byte(clsp_pkg::CH_NL);
            end
            n_lits = $urandom_range(1, 4);
            repeat (n_lits)
            begin
                repeat ($urandom_range(0, 1))
                    add_draft_byte(pick_blank());
                if ($urandom_range(9) < 4)
                    add_draft_byte(clsp_pkg::CH_MINUS);
                if ($urandom_range(9) == 0)
                    add_draft_byte(clsp_pkg::CH_ZERO);
                pick = $urandom_range(99);
                if (pick < 3)
                    add_draft_byte(clsp_pkg::CH_ZERO);
                else if (pick < 70)
                    draft_text($sformatf("%0d", $urandom_range(1, 99)));
                else if (pick < 88)
                    draft_text($sformatf("%0d", $urandom_range(1, 999999)));
                else if (pick < 95)
                    // Straddles the ceiling of the accumulator.
                    draft_text($sformatf("%0d", MAG_MAX - 1 + $urandom_range(3)));
                else
                    repeat ($urandom_range(9, 14))
                        add_draft_byte(8'($urandom_range(clsp_pkg::CH_ZERO,
                                                         clsp_pkg::CH_NINE)));
                add_draft_byte(pick_blank());
            end
            repeat ($urandom_range(0, 1))
                add_draft_byte(pick_blank());
            add_draft_byte(clsp_pkg::CH_ZERO);
            add_draft_byte(clsp_pkg::CH_NL);
        end
        shape = $urandom_range(9);
        noisy = ($urandom_range(4) == 0);
        cut   = (shape == 0) ? $urandom_range(draft.size() - 1) : draft.size() - 1;
        for (int i = 0; i <= cut; i++)
            add_byte((noisy && $urandom_range(9) == 0) ? 8'($urandom) : draft[i],
                     shape != 1 && i == cut);
    endtask

    // Waits until every queued byte has been taken and every predicted token has
    // come out, then lets the short latency of the block pass. A lost result does
    // not hang here; it is left in the store and reported at the end.
    task settle();
        int waited;
        waited = 0;
        while (text_bytes.size() != 0 || text_if.valid)
            @(posedge clk);
        while (parsed_tokens.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task check_field(input string name, input logic signed [63:0] want,
                     input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // A correct run ends well before this limit even with both sides idling.
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: inputs change on the falling edge. The valid item is held until it
    // has been taken, and the next one follows at once unless the sender idles.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : feed
        text_item_t nxt;
        if (rst_n)
        begin
            if (!text_if.valid || text_taken)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = text_bytes.pop_front();
                    text_if.valid         <= 1'b1;
                    text_if.char_code     <= nxt.code;
                    text_if.end_of_stream <= nxt.eos;
                end
                else
                begin
                    text_if.valid <= 1'b0;
                end
            end
            result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled on the rising edge. An accepted byte is
    // run through the prediction at once, and an accepted result is compared
    // with the oldest token still awaited.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watch
        cnf_result_t want;
        text_taken <= rst_n && text_if.valid && text_if.ready;
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                parse_byte(text_if.char_code, text_if.end_of_stream);
            if (result_if.valid && result_if.ready)
            begin
                if (parsed_tokens.size() == 0)
                begin
                    $error("unexpected result: out_kind %0b literal_value %0d",
                           result_if.out_kind, result_if.literal_value);
                    errors++;
                end
                else
                begin
                    want = parsed_tokens.pop_front();
                    check_field("out_kind", want.kind, result_if.out_kind);
                    check_field("literal_value", $signed(want.value),
                                result_if.literal_value);
                    check_field("magnitude_overflow", want.ovf,
                                result_if.magnitude_overflow);
                    check_field("run_last", want.last, result_if.run_last);
                    check_field("stream_done", want.done, result_if.stream_done);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int target;
        text_if.valid         = 1'b0;
        text_if.char_code     = '0;
        text_if.end_of_stream = 1'b0;
        result_if.ready       = 1'b0;
        text_taken            = 1'b0;
        queued                = 0;
        errors                = 0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        clear_parser();

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. A comment line at a clause start; a negative literal
        // one past the ceiling, so it saturates and raises the overflow flag; a
        // minus and a blank each ending a token ("1-2 "), then a bare minus ended
        // by a letter, which closes the clause; a digit carrying the end mark,
        // giving a literal and a clause end from one byte; a stray top-bit byte at
        // a clause start; and a problem line cut off by the end of the stream.
        add_text("c\n", 1'b0);
        add_text("-16777216 ", 1'b0);
        add_text("1-2 -x", 1'b0);
        add_text("7", 1'b1);
        add_byte(8'hFF, 1'b0);
        add_text("p 5", 1'b1);

        // Four idling phases: none, sender only, receiver only, and both. Each
        // phase is drained completely before the next one starts, so the sender
        // pauses until every token in flight has come out.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 61;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            target = queued + PHASE_BYTES;
            while (queued < target)
                add_random_stream();
            settle();
        end

        if (parsed_tokens.size() != 0)
        begin
            $error("%0d predicted results never arrived", parsed_tokens.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
